@@ design/rssi_device_table_locator_unit_assert.svh @@
// assertion macros for the rssi device table locator
// used by the top level only, needs clk and rst in scope
`ifndef RSSI_DEVICE_TABLE_LOCATOR_UNIT_ASSERT_SVH
`define RSSI_DEVICE_TABLE_LOCATOR_UNIT_ASSERT_SVH

// checked only out of reset
`define RDTL_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define RDTL_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rdtl_pkg.sv @@
// shared types, codes and the weight table builder for the device locator
// no dependencies
package rdtl_pkg;

  localparam int MAX_NODES        = 3;
  localparam int DEVICE_SLOTS_DEF = 32;
  localparam int NODES_DEF        = 3;
  localparam int PATH_EXP_DEF     = 25;
  localparam int MAX_RESULTS      = 32;
  localparam int MIN_NODES        = 2;
  localparam int W_W              = 17;   // weight width, weights stay below 2^16
  localparam int SX_W             = 36;   // weighted coordinate sum
  localparam int SW_W             = 19;   // weight sum
  localparam int DVD_W            = 36;   // rounded dividend magnitude
  localparam int Q_W              = 16;   // quotient magnitude
  localparam logic [63:0] TENTH_Q32 = 64'd429496730;

  // register indexes
  localparam logic [2:0] REG_TX    = 3'd0;
  localparam logic [2:0] REG_STALE = 3'd1;
  localparam logic [2:0] REG_N1X   = 3'd2;
  localparam logic [2:0] REG_N1Y   = 3'd3;
  localparam logic [2:0] REG_N2X   = 3'd4;
  localparam logic [2:0] REG_N2Y   = 3'd5;
  localparam logic [2:0] REG_N3X   = 3'd6;
  localparam logic [2:0] REG_N3Y   = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_POS    = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // command classes between front and back
  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_BAD    = 2'd1;
  localparam logic [1:0] CMD_SWEEP  = 2'd2;

  typedef struct packed {
    logic [7:0]                  ref_power;
    logic [31:0]                 stale_limit;
    logic [MAX_NODES-1:0][15:0]  node_x;
    logic [MAX_NODES-1:0][15:0]  node_y;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] hash;
    logic [1:0]  node;   // node number minus one
    logic [7:0]  rssi;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [31:0]                hash;
    logic [31:0]                time_ms;
    logic [31:0]                count;
    logic [MAX_NODES-1:0][7:0]  rssi;
    logic [MAX_NODES-1:0]       seen;
  } slot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [31:0] hash;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] seen_at;
    logic [31:0] total;
    logic        last;
  } result_t;

  typedef logic [W_W-1:0] wrom_t [256];

  function automatic logic [63:0] mulq32(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 32;
  endfunction

  // shift-subtract division, evaluated at elaboration only
  function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // q16.16 of 1/(dist^2 + 1e-4) for each path loss step
  function automatic wrom_t build_wrom(int pexp);
    wrom_t       rom;
    logic [63:0] lo, hi, mid, acc, f, t, num, den, w;
    lo = '0;
    hi = 64'hFFFF_FFFF;
    for (int it = 0; it < 40; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        acc = mid;
        for (int k = 1; k < 64; k++) begin
          if (k < pexp) acc = mulq32(acc, mid);
        end
        if (acc <= TENTH_Q32) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    f = lo;
    t = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      num    = t * 64'd655360000;
      den    = (64'd10000 << 32) + t;
      w      = long_div(num + (den >> 1), den);
      rom[i] = w[W_W-1:0];
      t      = mulq32(mulq32(t, f), f);
    end
    return rom;
  endfunction

endpackage

@@ design/rdtl_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module rdtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rdtl_front.sv @@
// input side: classifies each transaction and queues it for the engine
// depends on rdtl_pkg
module rdtl_front #(
  parameter int NODES = rdtl_pkg::NODES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  logic           mode,
  input  logic [31:0]    device_hash,
  input  logic [7:0]     node_number,
  input  logic [7:0]     rssi_dbm,
  input  logic [31:0]    now_ms,
  output logic           q_valid,
  output rdtl_pkg::cmd_t q_entry,
  input  logic           q_pop
);

  rdtl_pkg::cmd_t entries [2];
  rdtl_pkg::cmd_t incoming;
  logic           wptr, rptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    incoming.hash   = device_hash;
    incoming.node   = 2'(node_number - 8'd1);
    incoming.rssi   = rssi_dbm;
    incoming.now_ms = now_ms;
    priority if (mode) begin
      incoming.cmd = rdtl_pkg::CMD_SWEEP;
    end else if (node_number == 8'd0 || node_number > 8'(NODES)) begin
      incoming.cmd = rdtl_pkg::CMD_BAD;
    end else begin
      incoming.cmd = rdtl_pkg::CMD_REPORT;
    end
  end

  assign s_ready = (count != 2'd2);
  assign push    = s_valid && s_ready;
  assign q_valid = (count != 2'd0);
  assign q_entry = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= incoming;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ design/rdtl_div.sv @@
// sequential divider for the centroid, one quotient bit per cycle
// depends on rdtl_pkg
module rdtl_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rdtl_pkg::DVD_W-1:0] dividend,
  input  logic [rdtl_pkg::SW_W-1:0]  divisor,
  output logic                       done,
  output logic [rdtl_pkg::Q_W-1:0]   quotient
);

  localparam int RW = rdtl_pkg::SW_W + 1;

  logic [RW-1:0]              rem;
  logic [rdtl_pkg::Q_W-1:0]   dvd_lo;
  logic [rdtl_pkg::SW_W-1:0]  dsr;
  logic [4:0]                 cnt;
  logic                       busy;
  logic [RW-1:0]              trial;
  logic                       fits;

  assign trial = {rem[RW-2:0], dvd_lo[rdtl_pkg::Q_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient fits in Q_W bits, so the top part is already below the divisor
      rem      <= dividend[rdtl_pkg::DVD_W-1:rdtl_pkg::Q_W];
      dvd_lo   <= dividend[rdtl_pkg::Q_W-1:0];
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? trial - {1'b0, dsr} : trial;
      dvd_lo   <= {dvd_lo[rdtl_pkg::Q_W-2:0], 1'b0};
      quotient <= {quotient[rdtl_pkg::Q_W-2:0], fits};
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(rdtl_pkg::Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/rdtl_back.sv @@
// engine: slot table lookup and update, sweep with weighted centroid
// depends on rdtl_pkg, rdtl_ram, rdtl_div
module rdtl_back #(
  parameter int DEVICE_SLOTS    = rdtl_pkg::DEVICE_SLOTS_DEF,
  parameter int NODES           = rdtl_pkg::NODES_DEF,
  parameter int PATH_EXP_TENTHS = rdtl_pkg::PATH_EXP_DEF,
  parameter int AW              = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1,
  parameter int CW              = $clog2(DEVICE_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  rdtl_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  rdtl_pkg::cmd_t    q_entry,
  output logic              q_pop,
  output logic              m_valid,
  input  logic              m_ready,
  output rdtl_pkg::result_t m_res,
  output logic [CW-1:0]     slots_used
);

  localparam int KW = $clog2(rdtl_pkg::MAX_RESULTS + 1);
  localparam int SLOT_W = $bits(rdtl_pkg::slot_t);
  localparam rdtl_pkg::wrom_t WROM = rdtl_pkg::build_wrom(PATH_EXP_TENTHS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LK_RD  = 4'd1;
  localparam logic [3:0] ST_LK_CMP = 4'd2;
  localparam logic [3:0] ST_ALLOC  = 4'd3;
  localparam logic [3:0] ST_EMIT   = 4'd4;
  localparam logic [3:0] ST_SW_RD  = 4'd5;
  localparam logic [3:0] ST_SW_CHK = 4'd6;
  localparam logic [3:0] ST_SW_W   = 4'd7;
  localparam logic [3:0] ST_SW_M   = 4'd8;
  localparam logic [3:0] ST_SW_A   = 4'd9;
  localparam logic [3:0] ST_SW_SUM = 4'd10;
  localparam logic [3:0] ST_SW_DX  = 4'd11;
  localparam logic [3:0] ST_SW_DY  = 4'd12;
  localparam logic [3:0] ST_SW_PUSH = 4'd13;
  localparam logic [3:0] ST_SW_END = 4'd14;

  logic [3:0]                         state;
  rdtl_pkg::cmd_t                     cmd;
  logic [CW-1:0]                      idx;
  logic [KW-1:0]                      k;
  logic [1:0]                         n;
  rdtl_pkg::slot_t                    word;
  logic [rdtl_pkg::W_W-1:0]           w_r;
  logic signed [33:0]                 px, py;
  logic signed [rdtl_pkg::SX_W-1:0]   sx, sy;
  logic [rdtl_pkg::SW_W-1:0]          sw;
  logic [15:0]                        qx;
  rdtl_pkg::result_t                  hold, rep;
  logic                               hold_v;
  // a finished position waits here until the next one shows whether it is the final one
  rdtl_pkg::result_t                  prev_hold;
  rdtl_pkg::result_t                  rep_init, rep_upd, end_res, out_data;
  logic                               out_fire;
  logic                               push_go;
  logic                               skip_slot;

  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  rdtl_pkg::slot_t                    ram_wdata, ram_rdata;
  logic [SLOT_W-1:0]                  ram_rdata_raw;

  rdtl_pkg::slot_t                    upd_word, fresh_word;
  logic                               table_full;
  logic [AW-1:0]                      alloc_addr;
  logic                               out_free;
  logic                               is_stale;
  logic [1:0]                         seen_cnt;
  logic signed [8:0]                  loss;
  logic [7:0]                         loss_c;

  logic                               div_start, div_done;
  logic signed [rdtl_pkg::SX_W-1:0]   dvd_src;
  logic                               dvd_neg;
  logic [rdtl_pkg::DVD_W-1:0]         dvd_mag, dividend;
  logic [rdtl_pkg::Q_W-1:0]           quotient;
  logic [15:0]                        q_signed;
  rdtl_pkg::result_t                  pos_res;

  rdtl_ram #(.WIDTH(SLOT_W), .DEPTH(DEVICE_SLOTS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata_raw)
  );
  assign ram_rdata = ram_rdata_raw;

  rdtl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (sw),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_free   = !m_valid || m_ready;
  assign table_full = (slots_used == CW'(DEVICE_SLOTS));
  assign alloc_addr = table_full ? '0 : slots_used[AW-1:0];
  assign is_stale   = (cmd.now_ms - ram_rdata.time_ms) > cfg.stale_limit;
  assign skip_slot  = is_stale || (seen_cnt < 2'(rdtl_pkg::MIN_NODES));
  assign push_go    = (state == ST_SW_PUSH) && (!hold_v || out_free);
  assign out_fire   = out_free && ((state == ST_EMIT) || (state == ST_SW_END) ||
                                   (state == ST_SW_PUSH && hold_v));

  always_comb begin
    upd_word                = ram_rdata;
    upd_word.rssi[cmd.node] = cmd.rssi;
    upd_word.seen[cmd.node] = 1'b1;
    upd_word.time_ms        = cmd.now_ms;
    upd_word.count          = ram_rdata.count + 32'd1;

    fresh_word                = '0;
    fresh_word.hash           = cmd.hash;
    fresh_word.rssi[cmd.node] = cmd.rssi;
    fresh_word.seen[cmd.node] = 1'b1;
    fresh_word.time_ms        = cmd.now_ms;
    fresh_word.count          = 32'd1;

    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = upd_word;
    if (state == ST_LK_CMP && ram_rdata.hash == cmd.hash) begin
      ram_we = 1'b1;
    end else if (state == ST_ALLOC) begin
      ram_we    = 1'b1;
      ram_waddr = alloc_addr;
      ram_wdata = fresh_word;
    end
  end

  always_comb begin
    seen_cnt = '0;
    for (int j = 0; j < NODES; j++) begin
      seen_cnt = seen_cnt + 2'(ram_rdata.seen[j]);
    end
  end

  // report result templates
  always_comb begin
    rep_init        = '0;
    rep_init.kind   = rdtl_pkg::KIND_REPORT;
    rep_init.hash   = q_entry.hash;
    rep_init.last   = 1'b1;
    rep_init.status = (q_entry.cmd == rdtl_pkg::CMD_BAD);

    rep_upd         = rep;
    rep_upd.seen_at = cmd.now_ms;
    rep_upd.total   = (state == ST_ALLOC) ? 32'd1 : upd_word.count;
  end

  // final result of a sweep
  always_comb begin
    if (hold_v) begin
      end_res      = prev_hold;
      end_res.last = 1'b1;
    end else begin
      end_res      = '0;
      end_res.kind = rdtl_pkg::KIND_EMPTY;
      end_res.last = 1'b1;
    end
  end

  always_comb begin
    if (state == ST_EMIT) out_data = rep;
    else if (state == ST_SW_PUSH) out_data = prev_hold;
    else out_data = end_res;
  end

  // path loss step, clamped at zero
  assign loss   = $signed({cfg.ref_power[7], cfg.ref_power})
                - $signed({word.rssi[n][7], word.rssi[n]});
  assign loss_c = loss[8] ? 8'd0 : loss[7:0];

  assign dvd_src   = (state == ST_SW_SUM) ? sx : sy;
  assign dvd_neg   = dvd_src[rdtl_pkg::SX_W-1];
  assign dvd_mag   = dvd_neg ? rdtl_pkg::DVD_W'(-dvd_src) : rdtl_pkg::DVD_W'(dvd_src);
  assign dividend  = dvd_mag + rdtl_pkg::DVD_W'(sw >> 1);
  assign div_start = (state == ST_SW_SUM && sw != '0) || (state == ST_SW_DX && div_done);
  assign q_signed  = sy[rdtl_pkg::SX_W-1] ? (~quotient + 16'd1) : quotient;

  always_comb begin
    pos_res         = '0;
    pos_res.kind    = rdtl_pkg::KIND_POS;
    pos_res.hash    = word.hash;
    pos_res.pos_x   = qx;
    pos_res.pos_y   = q_signed;
    pos_res.seen_at = word.time_ms;
    pos_res.total   = word.count;
  end

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cmd <= q_entry;
          idx <= '0;
          k   <= '0;
          rep <= rep_init;
        end
      end
      ST_LK_CMP: begin
        if (ram_rdata.hash == cmd.hash) begin
          rep <= rep_upd;
        end else begin
          idx <= idx + CW'(1);
        end
      end
      ST_ALLOC: begin
        rep <= rep_upd;
      end
      ST_SW_CHK: begin
        word <= ram_rdata;
        n    <= '0;
        sx   <= '0;
        sy   <= '0;
        sw   <= '0;
      end
      ST_SW_W: begin
        w_r <= word.seen[n] ? WROM[loss_c] : '0;
      end
      ST_SW_M: begin
        px <= $signed({1'b0, w_r}) * $signed(cfg.node_x[n]);
        py <= $signed({1'b0, w_r}) * $signed(cfg.node_y[n]);
      end
      ST_SW_A: begin
        sx <= sx + rdtl_pkg::SX_W'(px);
        sy <= sy + rdtl_pkg::SX_W'(py);
        sw <= sw + rdtl_pkg::SW_W'(w_r);
        n  <= n + 2'd1;
      end
      ST_SW_DX: begin
        if (div_done) begin
          qx <= sx[rdtl_pkg::SX_W-1] ? (~quotient + 16'd1) : quotient;
        end
      end
      ST_SW_DY: begin
        if (div_done) begin
          hold <= pos_res;
        end
      end
      default: begin
      end
    endcase
    // skipped slots and pushed positions move to the next slot
    if ((state == ST_SW_CHK && skip_slot) || (state == ST_SW_SUM && sw == '0) || push_go) begin
      idx <= idx + CW'(1);
    end
    if (push_go) begin
      k <= k + KW'(1);
    end

    if (rst) begin
      state      <= ST_IDLE;
      slots_used <= '0;
      hold_v     <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      m_valid <= out_fire || (m_valid && !m_ready);
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_entry.cmd)
              rdtl_pkg::CMD_SWEEP:  state <= ST_SW_RD;
              rdtl_pkg::CMD_REPORT: state <= (slots_used == '0) ? ST_ALLOC : ST_LK_RD;
              default:              state <= ST_EMIT;
            endcase
            hold_v <= 1'b0;
          end
        end
        ST_LK_RD: state <= ST_LK_CMP;
        ST_LK_CMP: begin
          priority if (ram_rdata.hash == cmd.hash) state <= ST_EMIT;
          else if (idx + CW'(1) == slots_used) state <= ST_ALLOC;
          else state <= ST_LK_RD;
        end
        ST_ALLOC: begin
          if (!table_full) slots_used <= slots_used + CW'(1);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) state <= ST_IDLE;
        end
        ST_SW_RD: begin
          if (idx == slots_used || k == KW'(rdtl_pkg::MAX_RESULTS)) state <= ST_SW_END;
          else state <= ST_SW_CHK;
        end
        ST_SW_CHK: begin
          state <= skip_slot ? ST_SW_RD : ST_SW_W;
        end
        ST_SW_W: state <= ST_SW_M;
        ST_SW_M: state <= ST_SW_A;
        ST_SW_A: state <= (n == 2'(NODES - 1)) ? ST_SW_SUM : ST_SW_W;
        ST_SW_SUM: state <= (sw == '0) ? ST_SW_RD : ST_SW_DX;
        ST_SW_DX: if (div_done) state <= ST_SW_DY;
        ST_SW_DY: if (div_done) state <= ST_SW_PUSH;
        ST_SW_PUSH: begin
          if (push_go) begin
            hold_v <= 1'b1;
            state  <= ST_SW_RD;
          end
        end
        ST_SW_END: begin
          if (out_free) begin
            hold_v <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      m_res <= out_data;
    end
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      prev_hold <= hold;
    end
  end

endmodule

@@ design/rssi_device_table_locator_unit.sv @@
// top level of the rssi device table locator: config registers, front, engine
// depends on rdtl_pkg, rdtl_front, rdtl_back and the assertion header
//
// channel  | group   | contents
// input    | s_axis  | tuser: mode; tdata: hash, node, rssi, time
// result   | m_axis  | tuser: kind; tdata: status .. total; tlast: last
// config   | cfg_*   | plain write, index 0..7, no read-back
//
// a report reads and compares the stored slots one at a time, then allocates if needed and emits
// a sweep reads and checks each slot in turn; the time for each position found is
// set by the node-serial weight multiply and two 16-step divisions
// the input queue holds two transactions, so input accepts while a result waits
// reset clears control only; table entries are read only after being written
module rssi_device_table_locator_unit #(
  parameter int DEVICE_SLOTS    = rdtl_pkg::DEVICE_SLOTS_DEF,
  parameter int NODES           = rdtl_pkg::NODES_DEF,
  parameter int PATH_EXP_TENTHS = rdtl_pkg::PATH_EXP_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // device_hash, node_number, rssi_dbm, now_ms
  input  logic         s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // status, out_hash, pos_x_cm, pos_y_cm,
                                       // seen_at_ms, reading_total, zero fill
  output logic [1:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  `include "rssi_device_table_locator_unit_assert.svh"

  localparam int CW = $clog2(DEVICE_SLOTS + 1);

  rdtl_pkg::cfg_t    cfg;
  logic              q_valid, q_pop;
  rdtl_pkg::cmd_t    q_entry;
  rdtl_pkg::result_t res;
  logic [CW-1:0]     slots_used;
  logic              out_empty, out_report;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{ref_power: 8'hC5, stale_limit: 32'd30000, node_x: '0, node_y: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdtl_pkg::REG_TX:    cfg.ref_power   <= cfg_data[7:0];
        rdtl_pkg::REG_STALE: cfg.stale_limit <= cfg_data;
        rdtl_pkg::REG_N1X:   cfg.node_x[0]   <= cfg_data[15:0];
        rdtl_pkg::REG_N1Y:   cfg.node_y[0]   <= cfg_data[15:0];
        rdtl_pkg::REG_N2X:   cfg.node_x[1]   <= cfg_data[15:0];
        rdtl_pkg::REG_N2Y:   cfg.node_y[1]   <= cfg_data[15:0];
        rdtl_pkg::REG_N3X:   cfg.node_x[2]   <= cfg_data[15:0];
        rdtl_pkg::REG_N3Y:   cfg.node_y[2]   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  rdtl_front #(.NODES(NODES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .mode        (s_axis_tuser),
    .device_hash (s_axis_tdata[31:0]),
    .node_number (s_axis_tdata[39:32]),
    .rssi_dbm    (s_axis_tdata[47:40]),
    .now_ms      (s_axis_tdata[79:48]),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop)
  );

  rdtl_back #(
    .DEVICE_SLOTS    (DEVICE_SLOTS),
    .NODES           (NODES),
    .PATH_EXP_TENTHS (PATH_EXP_TENTHS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_res      (res),
    .slots_used (slots_used)
  );

  assign m_axis_tdata = {7'd0, res.total, res.seen_at, res.pos_y, res.pos_x,
                         res.hash, res.status};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  assign out_empty  = m_axis_tvalid && (m_axis_tuser == rdtl_pkg::KIND_EMPTY);
  assign out_report = m_axis_tvalid && (m_axis_tuser == rdtl_pkg::KIND_REPORT);

  `RDTL_CHECK_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid && s_axis_tready, "busy after reset")
  `RDTL_CHECK(a_slots_bound, slots_used <= CW'(DEVICE_SLOTS), "slot count overflow")
  `RDTL_CHECK(a_empty_last, out_empty |-> m_axis_tlast, "empty sweep not last")
  `RDTL_CHECK(a_report_last, out_report |-> m_axis_tlast, "report result not last")
  `RDTL_CHECK(a_status_kind, m_axis_tvalid && m_axis_tdata[0] |-> out_report, "status misplaced")

endmodule
